@@ rtl/core/slis_pkg.sv @@
package slis_pkg;

   localparam int VALUE_W  = 32;
   localparam int FUNC_W   = 2;
   localparam int POS_W    = 7;
   localparam int INDEX_W  = 6;
   localparam int STATUS_W = 2;
   localparam int POS_CHK_W = 8;

   localparam logic [FUNC_W-1:0] FUNC_FRONT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_REAR  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_POS   = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BADPOS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } slis_state_type;

   // Commands broadcast from the controller to every cell of the chain.
   typedef struct packed {
      logic               ins;
      logic               rot;
      logic [VALUE_W-1:0] value;
   } slis_ctrl_type;

endpackage

@@ rtl/core/slis_cell.sv @@
module slis_cell
   import slis_pkg::*;
(
   input  logic               clock,
   input  slis_ctrl_type      ctrl,
   input  logic               valid,
   input  logic               left_valid,
   input  logic               left_take,
   input  logic [VALUE_W-1:0] left_val,
   input  logic               right_valid,
   input  logic [VALUE_W-1:0] right_val,
   input  logic [VALUE_W-1:0] head_val,
   output logic [VALUE_W-1:0] val,
   output logic               take
);

   logic [VALUE_W-1:0] val_ff;
   logic [VALUE_W-1:0] val_in;

   // A cell yields its place when it is empty or holds a strictly larger value,
   // so a new value lands after any equal values already held.
   assign take = !valid || ($signed(ctrl.value) < $signed(val_ff));
   assign val  = val_ff;

   always_comb begin
      val_in = val_ff;
      if (ctrl.ins) begin
         if (take && left_valid) begin
            val_in = left_take ? left_val : ctrl.value;
         end
      end else if (ctrl.rot) begin
         if (valid) begin
            val_in = right_valid ? right_val : head_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

endmodule

@@ rtl/core/sorted_list_insert_unit.sv @@
// Sorted list insert unit.
// The block keeps up to CAPACITY signed 32-bit values in ascending order in a
// chain of cells. Each request transfer on the req_ channel asks to insert one
// value at the front, the rear or a given 1-based position; the value always
// lands at its sorted place, and the position only decides whether the request
// is valid. A full list or a bad position leaves the list unchanged.
// After every request the whole list is sent on the rsp_ channel, one element
// per transfer in ascending order, with rsp_tlast on the final one. An empty
// list gives a single transfer with the empty flag set and element zero.
// The insert itself happens in the cycle of the request transfer; the first
// response is offered in the next cycle. Each response transfer rotates the
// chain by one cell, so after count transfers the list is back in place.
// req_tready is high only while no response is pending, so a new request is
// taken only after the last response of the previous one has been sent.
// When the receiver holds rsp_tready low, the current response stays on the
// port and the chain does not move.
// Reset empties the list at once and returns the block to waiting for a
// request; no clearing pass is needed.
module sorted_list_insert_unit
   import slis_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // value [31:0], position [38:32], zero fill
   input  logic [1:0]  req_tuser,  // func [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // element [31:0], index [37:32], zero fill
   output logic        rsp_tlast,
   output logic [2:0]  rsp_tuser   // status [1:0], empty_res [2]
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   slis_state_type       state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [STATUS_W-1:0]  status_ff, status_in;

   slis_ctrl_type        ctrl;
   logic [FUNC_W-1:0]    req_func;
   logic [VALUE_W-1:0]   req_value;
   logic [POS_W-1:0]     req_pos;
   logic                 list_full;
   logic                 pos_bad;
   logic                 is_empty;
   logic                 is_last;

   logic [VALUE_W-1:0]   cell_val  [CAPACITY];
   logic                 cell_take [CAPACITY];
   logic                 cell_valid[CAPACITY];

   assign req_func  = req_tuser;
   assign req_value = req_tdata[VALUE_W-1:0];
   assign req_pos   = req_tdata[VALUE_W+POS_W-1:VALUE_W];

   assign list_full = (count_ff == CNT_W'(CAPACITY));
   assign pos_bad   = (req_pos == '0) ||
                      (POS_CHK_W'(req_pos) > (POS_CHK_W'(count_ff) + POS_CHK_W'(1)));
   assign is_empty  = (count_ff == '0);
   assign is_last   = is_empty || (CNT_W'(idx_ff) == (count_ff - CNT_W'(1)));

   // Cells below the fill count hold the list; the rest are empty.
   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_valid
         assign cell_valid[gi] = (CNT_W'(gi) < count_ff);
      end

      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic               lv, lt, rv;
         logic [VALUE_W-1:0] lval, rval;
         if (gi == 0) begin : g_head
            assign lv   = 1'b1;
            assign lt   = 1'b0;
            assign lval = '0;
         end else begin : g_mid
            assign lv   = cell_valid[gi-1];
            assign lt   = cell_take[gi-1];
            assign lval = cell_val[gi-1];
         end
         if (gi == CAPACITY - 1) begin : g_tail
            assign rv   = 1'b0;
            assign rval = '0;
         end else begin : g_body
            assign rv   = cell_valid[gi+1];
            assign rval = cell_val[gi+1];
         end
         slis_cell u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .valid       (cell_valid[gi]),
            .left_valid  (lv),
            .left_take   (lt),
            .left_val    (lval),
            .right_valid (rv),
            .right_val   (rval),
            .head_val    (cell_val[0]),
            .val         (cell_val[gi]),
            .take        (cell_take[gi])
         );
      end
   endgenerate

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      status_in  = status_ff;
      ctrl.ins   = 1'b0;
      ctrl.rot   = 1'b0;
      ctrl.value = req_value;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_func != FUNC_FRONT && req_func != FUNC_REAR &&
                   req_func != FUNC_POS) begin
                  status_in = STATUS_BADPOS;
               end else if (list_full) begin
                  status_in = STATUS_FULL;
               end else if (req_func == FUNC_POS && pos_bad) begin
                  status_in = STATUS_BADPOS;
               end else begin
                  status_in = STATUS_OK;
                  ctrl.ins  = 1'b1;
                  count_in  = count_ff + CNT_W'(1);
               end
               idx_in   = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               // Rotating the chain brings the next element to the head cell.
               ctrl.rot = !is_empty;
               idx_in   = idx_ff + IDX_W'(1);
               if (is_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
      status_ff <= status_in;
   end

   assign rsp_tdata = {2'b00, INDEX_W'(idx_ff), is_empty ? VALUE_W'(0) : cell_val[0]};
   assign rsp_tlast = is_last;
   assign rsp_tuser = {is_empty, status_ff};

endmodule
